// ----- src/rpa_pkg.sv -----
// Shared types, codes and default sizes for the reference-counted page allocator.
package rpa_pkg;

  // Default sizes of the page tables.
  localparam int NUM_PAGES_DEF  = 1024;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed field widths of the beats.
  localparam int CMD_W    = 3;
  localparam int ADDR_W   = 32;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 3;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FREE     = 3'd0,
    CMD_ADD_RESERVED = 3'd1,
    CMD_ALLOCATE     = 3'd2,
    CMD_REFERENCE    = 3'd3,
    CMD_UNREFERENCE  = 3'd4
  } cmd_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EXISTS   = 3'd1,
    ST_FAULT    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_we;  // write zero to the count entry under the sweep pointer
    logic load;      // take an input beat and start the table reads
    logic commit;    // write the tables and load the result register
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_done;  // sweep pointer is at the last entry
    logic out_free;    // result register can take a new beat this cycle
  } dp_status_t;

endpackage

// ----- src/rpa_ctrl.sv -----
// Controller state machine: clearing sweep, beat acceptance and commit sequencing.
module rpa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rpa_pkg::dp_status_t dp_status,
  output rpa_pkg::ctrl_cmd_t  ctrl_cmd
);
  import rpa_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command outputs.
  always_comb begin
    state_next = state;
    ctrl_cmd   = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_CLEAR: begin
        ctrl_cmd.clear_we = 1'b1;
        if (dp_status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl_cmd.load = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (dp_status.out_free) begin
          ctrl_cmd.commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- src/rpa_datapath.sv -----
// Datapath: count and link tables, free list head, command evaluation and result register.
module rpa_datapath #(
  parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rpa_pkg::ctrl_cmd_t            ctrl_cmd,
  output rpa_pkg::dp_status_t           dp_status,
  input  logic [rpa_pkg::CMD_W-1:0]     command,
  input  logic [rpa_pkg::ADDR_W-1:0]    page_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rpa_pkg::ADDR_W-1:0]    address,
  output logic [rpa_pkg::COUNT_W-1:0]   count,
  output logic [rpa_pkg::STATUS_W-1:0]  status
);
  import rpa_pkg::*;

  localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(NUM_PAGES - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_TWO  = COUNT_BITS'(2);

  // Table storage.
  logic [COUNT_BITS-1:0] ref_mem  [NUM_PAGES];
  logic [IDX_W-1:0]      next_mem [NUM_PAGES];

  // Registered read data and the captured beat.
  logic [COUNT_BITS-1:0] ref_rd;
  logic [IDX_W-1:0]      next_rd;
  logic [CMD_W-1:0]      cmd_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  in_range_q;

  // Free list head and sweep pointer.
  logic [IDX_W-1:0]      free_head;
  logic                  free_nonempty;
  logic [IDX_W-1:0]      clr_ptr;

  // Decoded page index of the incoming beat.
  logic [ADDR_W:0]       page_num;
  logic [IDX_W-1:0]      in_idx;
  logic                  in_range;

  // Evaluation results.
  logic                  op_ref_we;
  logic [IDX_W-1:0]      op_ref_waddr;
  logic [COUNT_BITS-1:0] op_ref_wdata;
  logic                  op_next_we;
  logic [IDX_W-1:0]      op_next_wdata;
  logic [IDX_W-1:0]      free_head_next;
  logic                  free_nonempty_next;
  logic [ADDR_W-1:0]     res_address;
  logic [COUNT_BITS-1:0] res_count_full;
  status_t               res_status;
  logic [63:0]           alloc_wide;
  logic [31:0]           res_count32;

  logic                  ref_we;
  logic [IDX_W-1:0]      ref_waddr;
  logic [COUNT_BITS-1:0] ref_wdata;

  // Page index and range check of the input beat.
  assign page_num = (ADDR_W + 1)'(page_address >> PAGE_SHIFT);
  assign in_idx   = page_num[IDX_W-1:0];
  assign in_range = page_num < (ADDR_W + 1)'(NUM_PAGES);

  // Capture the beat when the controller takes it.
  always_ff @(posedge clk) begin
    if (ctrl_cmd.load) begin
      cmd_q      <= command;
      idx_q      <= in_idx;
      in_range_q <= in_range;
    end
  end

  // Evaluate the captured command against the read table entries.
  always_comb begin
    op_ref_we          = 1'b0;
    op_ref_waddr       = idx_q;
    op_ref_wdata       = CNT_TWO;
    op_next_we         = 1'b0;
    op_next_wdata      = free_nonempty ? free_head : idx_q;
    free_head_next     = free_head;
    free_nonempty_next = free_nonempty;
    res_count_full     = '0;
    res_status         = ST_OK;
    alloc_wide         = 64'(free_head) << PAGE_SHIFT;
    res_address        = '0;
    unique case (cmd_q)
      CMD_ADD_FREE, CMD_ADD_RESERVED: begin
        if (!in_range_q) begin
          res_status = ST_FAULT;
        end else if (ref_rd != '0) begin
          res_status = ST_EXISTS;
        end else if (cmd_q == CMD_ADD_RESERVED) begin
          op_ref_we = 1'b1;
        end else begin
          // Push the new page onto the free list.
          op_ref_we          = 1'b1;
          op_ref_wdata       = CNT_ONE;
          op_next_we         = 1'b1;
          free_head_next     = idx_q;
          free_nonempty_next = 1'b1;
        end
      end
      CMD_ALLOCATE: begin
        if (!free_nonempty) begin
          res_status = ST_EMPTY;
        end else begin
          // Pop the head; a page that links to itself is the bottom.
          op_ref_we    = 1'b1;
          op_ref_waddr = free_head;
          res_address  = alloc_wide[ADDR_W-1:0];
          if (next_rd == free_head) begin
            free_nonempty_next = 1'b0;
          end else begin
            free_head_next = next_rd;
          end
        end
      end
      CMD_REFERENCE: begin
        if (!in_range_q || ref_rd < CNT_TWO) begin
          res_status = ST_FAULT;
        end else if (ref_rd == CNT_MAX) begin
          res_status     = ST_OVERFLOW;
          res_count_full = ref_rd;
        end else begin
          op_ref_we      = 1'b1;
          op_ref_wdata   = ref_rd + CNT_ONE;
          res_count_full = op_ref_wdata;
        end
      end
      CMD_UNREFERENCE: begin
        if (!in_range_q || ref_rd < CNT_TWO) begin
          res_status = ST_FAULT;
        end else begin
          op_ref_we      = 1'b1;
          op_ref_wdata   = ref_rd - CNT_ONE;
          res_count_full = op_ref_wdata;
          // The last user left: the page goes back on the free list.
          if (op_ref_wdata == CNT_ONE) begin
            op_next_we         = 1'b1;
            free_head_next     = idx_q;
            free_nonempty_next = 1'b1;
          end
        end
      end
      default: begin
        res_status = ST_FAULT;
      end
    endcase
  end

  assign res_count32 = 32'(res_count_full);

  // Count table port: sweep writes during clearing, op writes at commit.
  assign ref_we    = ctrl_cmd.clear_we | (ctrl_cmd.commit & op_ref_we);
  assign ref_waddr = ctrl_cmd.clear_we ? clr_ptr : op_ref_waddr;
  assign ref_wdata = ctrl_cmd.clear_we ? '0 : op_ref_wdata;

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    if (ctrl_cmd.load) begin
      ref_rd <= ref_mem[in_idx];
    end
  end

  // Link table: the head's link is read at load, the pushed page's link written at commit.
  always_ff @(posedge clk) begin
    if (ctrl_cmd.commit && op_next_we) begin
      next_mem[idx_q] <= op_next_wdata;
    end
    if (ctrl_cmd.load) begin
      next_rd <= next_mem[free_head];
    end
  end

  // Free list head.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head     <= '0;
      free_nonempty <= 1'b0;
    end else if (ctrl_cmd.commit) begin
      free_head     <= free_head_next;
      free_nonempty <= free_nonempty_next;
    end
  end

  // Clearing sweep pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (ctrl_cmd.clear_we && clr_ptr != LAST_IDX) begin
      clr_ptr <= clr_ptr + IDX_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl_cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.commit) begin
      address <= res_address;
      count   <= res_count32[COUNT_W-1:0];
      status  <= res_status;
    end
  end

  assign dp_status.clear_done = (clr_ptr == LAST_IDX);
  assign dp_status.out_free   = !out_valid || !out_stall;

endmodule

// ----- src/refcounted_page_allocator.sv -----
// Reference-counted page frame allocator: one result beat per command beat.
// Each accepted command beat is captured and evaluated in S_EXEC; its result is registered
// into the result register at commit, which waits while a held result beat is stalled.
// A new command is not accepted until the previous one is committed; the count and link tables
// are read synchronously on the accepting edge and written back at commit.
// Reset: synchronous; a clearing pass zeroes the count table one entry per cycle,
// with in_stall held high until it finishes.
module refcounted_page_allocator #(
  parameter int NUM_PAGES  = rpa_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rpa_pkg::CMD_W-1:0]     command,
  input  logic [rpa_pkg::ADDR_W-1:0]    page_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rpa_pkg::ADDR_W-1:0]    address,
  output logic [rpa_pkg::COUNT_W-1:0]   count,
  output logic [rpa_pkg::STATUS_W-1:0]  status
);
  import rpa_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // Controller.
  rpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dp_status (dp_status),
    .ctrl_cmd  (ctrl_cmd)
  );

  // Datapath.
  rpa_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl_cmd     (ctrl_cmd),
    .dp_status    (dp_status),
    .command      (command),
    .page_address (page_address),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .address      (address),
    .count        (count),
    .status       (status)
  );

  // An accepted beat blocks the input until its result is committed.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a command is in flight");

  // A commit always leaves a result beat on the output.
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.commit |=> out_valid)
    else $error("committed result not presented");

  // The clearing pass starts right after reset with the input blocked.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_stall && ctrl_cmd.clear_we)
    else $error("no clearing pass after reset");

  // A nonzero count only comes with success or overflow, and never with an address.
  a_count_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && count != '0 |->
      (status == ST_OK || status == ST_OVERFLOW) && address == '0)
    else $error("count reported with a wrong status or an address");

  // A nonzero address only comes from a successful allocate.
  a_addr_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && address != '0 |-> status == ST_OK && count == '0)
    else $error("address reported without a successful allocate");

endmodule
